### src/nta_pkg.sv
package nta_pkg;

  // entry status codes
  typedef enum logic [1:0] {
    ST_OFFLINE = 2'd0,
    ST_PRESENT = 2'd1,
    ST_NEW     = 2'd2
  } status_t;

  // tick classification made by the front
  typedef enum logic {
    TICK_AGE    = 1'b0,
    TICK_BEACON = 1'b1
  } tick_kind_t;

  // back state machine
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_WALK,
    BK_APPEND,
    BK_PRIME,
    BK_EMIT,
    BK_EMPTY
  } back_state_t;

  // one tick as it travels through the queue
  typedef struct packed {
    tick_kind_t  kind;
    logic [31:0] ip;
    logic [15:0] port;
    logic [31:0] now;
  } tick_t;

  // one neighbour table entry
  typedef struct packed {
    logic [31:0] ip;
    logic [15:0] port;
    status_t     status;
    logic [31:0] seen;
  } entry_t;

  // one result item
  typedef struct packed {
    logic        entry_valid;
    logic [3:0]  entry_index;
    logic [31:0] ip;
    logic [15:0] port;
    logic [1:0]  status;
    logic [31:0] seen;
    logic        dropped;
    logic        last;
  } result_t;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_OUT_W   = 4;

  localparam logic [15:0] DECAY_RESET = 16'd5;

endpackage

### src/nta_in_if.sv
interface nta_in_if;
  logic        valid;
  logic        ready;
  logic        beacon_valid;
  logic [31:0] beacon_ip;
  logic [15:0] beacon_port;
  logic [31:0] now_seconds;

  modport source (
    output valid, beacon_valid, beacon_ip, beacon_port, now_seconds,
    input  ready
  );

  modport sink (
    input  valid, beacon_valid, beacon_ip, beacon_port, now_seconds,
    output ready
  );
endinterface

### src/nta_out_if.sv
interface nta_out_if;
  logic        valid;
  logic        ready;
  logic        entry_valid;
  logic [3:0]  entry_index;
  logic [31:0] entry_ip;
  logic [15:0] entry_port;
  logic [1:0]  entry_status;
  logic [31:0] last_seen_seconds;
  logic        beacon_dropped;
  logic        last;

  modport source (
    output valid, entry_valid, entry_index, entry_ip, entry_port, entry_status,
           last_seen_seconds, beacon_dropped, last,
    input  ready
  );

  modport sink (
    input  valid, entry_valid, entry_index, entry_ip, entry_port, entry_status,
           last_seen_seconds, beacon_dropped, last,
    output ready
  );
endinterface

### src/nta_front.sv
module nta_front (
  input  logic           clk,
  input  logic           rst_n,
  nta_in_if.sink         in_ch,
  output logic           push_valid,
  output nta_pkg::tick_t push_item,
  input  logic           push_full
);

  logic           hold_valid_r;
  logic           hold_valid_nxt;
  nta_pkg::tick_t hold_r;
  nta_pkg::tick_t hold_nxt;
  logic           in_xfer;

  // stage is free when empty or when its tick moves into the queue
  assign in_ch.ready = !hold_valid_r || !push_full;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  assign push_valid = hold_valid_r;
  assign push_item  = hold_r;

  // classify the tick, address fields cleared when no beacon came
  always_comb begin
    hold_valid_nxt = in_xfer || (hold_valid_r && push_full);
    hold_nxt       = hold_r;
    if (in_xfer) begin
      hold_nxt.now = in_ch.now_seconds;
      if (in_ch.beacon_valid) begin
        hold_nxt.kind = nta_pkg::TICK_BEACON;
        hold_nxt.ip   = in_ch.beacon_ip;
        hold_nxt.port = in_ch.beacon_port;
      end else begin
        hold_nxt.kind = nta_pkg::TICK_AGE;
        hold_nxt.ip   = '0;
        hold_nxt.port = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
    hold_r <= hold_nxt;
  end

endmodule

### src/nta_queue.sv
module nta_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  input  nta_pkg::tick_t push_item,
  output logic           full,
  input  logic           pop_ready,
  output logic           pop_valid,
  output nta_pkg::tick_t pop_item
);

  nta_pkg::tick_t                   slot_r [nta_pkg::QUEUE_DEPTH];
  logic [nta_pkg::QPTR_W-1:0]       wr_ptr_r;
  logic [nta_pkg::QPTR_W-1:0]       rd_ptr_r;
  logic [nta_pkg::QCNT_W-1:0]       cnt_r;
  logic                             push;
  logic                             pop;

  assign full      = (cnt_r == nta_pkg::QCNT_W'(nta_pkg::QUEUE_DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_item  = slot_r[rd_ptr_r];
  assign push      = push_valid && !full;
  assign pop       = pop_ready && pop_valid;

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // tick storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### src/nta_back.sv
module nta_back #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [15:0]                          cfg_wdata,
  input  logic                                 pop_valid,
  input  nta_pkg::tick_t                       pop_item,
  output logic                                 pop_ready,
  nta_out_if.source                            out_ch,
  output logic [$clog2(TABLE_DEPTH + 1)-1:0]   fill_count
);

  localparam int CNTW = $clog2(TABLE_DEPTH + 1);
  localparam int IDXW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  nta_pkg::back_state_t state_r, state_nxt;
  nta_pkg::tick_t       tick_r, tick_nxt;
  logic [CNTW-1:0]      i_r, i_nxt;
  logic [CNTW-1:0]      fill_r, fill_nxt;
  logic                 found_r, found_nxt;
  logic                 dropped_r, dropped_nxt;
  logic [15:0]          decay_r;
  logic                 out_valid_r, out_valid_nxt;
  nta_pkg::result_t     out_res_r, out_res_nxt;

  // table memory, one read and one write port
  nta_pkg::entry_t      mem [TABLE_DEPTH];
  nta_pkg::entry_t      rd_data_r;
  logic [IDXW-1:0]      rd_addr;
  logic                 mem_we;
  logic [IDXW-1:0]      mem_waddr;
  nta_pkg::entry_t      mem_wdata;

  logic [CNTW-1:0]      idx_inc;
  logic [CNTW+3:0]      idx_ext;
  logic                 is_beacon;
  logic                 match;
  logic [31:0]          age;
  logic                 stale;
  nta_pkg::entry_t      upd_entry;
  logic                 out_free;

  assign fill_count = fill_r;
  assign idx_inc    = i_r + 1'b1;
  assign idx_ext    = {4'b0000, i_r};
  assign is_beacon  = (tick_r.kind == nta_pkg::TICK_BEACON);
  assign out_free   = !out_valid_r || out_ch.ready;

  // per-entry update: first match is refreshed, others may age out
  assign match = is_beacon && !found_r && (rd_data_r.ip == tick_r.ip) &&
                 (rd_data_r.port == tick_r.port);
  assign age   = tick_r.now - rd_data_r.seen;
  assign stale = (rd_data_r.status != nta_pkg::ST_OFFLINE) && (age > {16'h0000, decay_r});

  always_comb begin
    upd_entry = rd_data_r;
    if (match) begin
      upd_entry.seen   = tick_r.now;
      upd_entry.status = (rd_data_r.status == nta_pkg::ST_OFFLINE) ?
                         nta_pkg::ST_NEW : nta_pkg::ST_PRESENT;
    end else if (stale) begin
      upd_entry.status = nta_pkg::ST_OFFLINE;
    end
  end

  // sequencer: update pass, append, then emission pass
  always_comb begin
    state_nxt     = state_r;
    tick_nxt      = tick_r;
    i_nxt         = i_r;
    fill_nxt      = fill_r;
    found_nxt     = found_r;
    dropped_nxt   = dropped_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_res_nxt   = out_res_r;
    pop_ready     = 1'b0;
    rd_addr       = '0;
    mem_we        = 1'b0;
    mem_waddr     = i_r[IDXW-1:0];
    mem_wdata     = upd_entry;

    case (state_r)
      nta_pkg::BK_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          tick_nxt    = pop_item;
          i_nxt       = '0;
          found_nxt   = 1'b0;
          dropped_nxt = 1'b0;
          state_nxt   = (fill_r == '0) ? nta_pkg::BK_APPEND : nta_pkg::BK_WALK;
        end
      end

      nta_pkg::BK_WALK: begin
        mem_we = 1'b1;
        if (match) begin
          found_nxt = 1'b1;
        end
        if (idx_inc == fill_r) begin
          state_nxt = nta_pkg::BK_APPEND;
        end else begin
          i_nxt   = idx_inc;
          rd_addr = idx_inc[IDXW-1:0];
        end
      end

      nta_pkg::BK_APPEND: begin
        if (is_beacon && !found_r) begin
          if (fill_r != CNTW'(TABLE_DEPTH)) begin
            mem_we           = 1'b1;
            mem_waddr        = fill_r[IDXW-1:0];
            mem_wdata.ip     = tick_r.ip;
            mem_wdata.port   = tick_r.port;
            mem_wdata.status = nta_pkg::ST_NEW;
            mem_wdata.seen   = tick_r.now;
            fill_nxt         = fill_r + 1'b1;
          end else begin
            dropped_nxt = 1'b1;
          end
        end
        state_nxt = nta_pkg::BK_PRIME;
      end

      nta_pkg::BK_PRIME: begin
        i_nxt     = '0;
        state_nxt = (fill_r == '0) ? nta_pkg::BK_EMPTY : nta_pkg::BK_EMIT;
      end

      nta_pkg::BK_EMIT: begin
        rd_addr = i_r[IDXW-1:0];
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_res_nxt.entry_valid = 1'b1;
          out_res_nxt.entry_index = idx_ext[nta_pkg::IDX_OUT_W-1:0];
          out_res_nxt.ip          = rd_data_r.ip;
          out_res_nxt.port        = rd_data_r.port;
          out_res_nxt.status      = rd_data_r.status;
          out_res_nxt.seen        = rd_data_r.seen;
          out_res_nxt.dropped     = dropped_r;
          out_res_nxt.last        = (idx_inc == fill_r);
          if (idx_inc == fill_r) begin
            state_nxt = nta_pkg::BK_IDLE;
          end else begin
            i_nxt   = idx_inc;
            rd_addr = idx_inc[IDXW-1:0];
          end
        end
      end

      nta_pkg::BK_EMPTY: begin
        if (out_free) begin
          out_valid_nxt       = 1'b1;
          out_res_nxt         = '0;
          out_res_nxt.dropped = dropped_r;
          out_res_nxt.last    = 1'b1;
          state_nxt           = nta_pkg::BK_IDLE;
        end
      end

      default: begin
        state_nxt = nta_pkg::BK_IDLE;
      end
    endcase
  end

  // control registers and decay setting
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nta_pkg::BK_IDLE;
      i_r         <= '0;
      fill_r      <= '0;
      found_r     <= 1'b0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
      decay_r     <= nta_pkg::DECAY_RESET;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      fill_r      <= fill_nxt;
      found_r     <= found_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        decay_r <= cfg_wdata;
      end
    end
    tick_r    <= tick_nxt;
    out_res_r <= out_res_nxt;
  end

  // table memory with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  // result register drives the output channel
  assign out_ch.valid             = out_valid_r;
  assign out_ch.entry_valid       = out_res_r.entry_valid;
  assign out_ch.entry_index       = out_res_r.entry_index;
  assign out_ch.entry_ip          = out_res_r.ip;
  assign out_ch.entry_port        = out_res_r.port;
  assign out_ch.entry_status      = out_res_r.status;
  assign out_ch.last_seen_seconds = out_res_r.seen;
  assign out_ch.beacon_dropped    = out_res_r.dropped;
  assign out_ch.last              = out_res_r.last;

endmodule

### src/neighbour_table_aging.sv
// channel  | dir | handshake          | carries
// in_ch    | in  | valid/ready        | one tick: beacon flag, address, port, time
// out_ch   | out | valid/ready        | one table entry per transfer, last on the final one
// cfg_*    | in  | write enable only  | decay_seconds, 16 bits
//
// in the back a tick walks the M entries present before it, then emits the N entries
// present after it, or a single empty-table result when the table stays empty; a tick
// passes the front stage and the queue before the back picks it up
// the table memory (one read, one write port) is walked once to age and refresh,
// once to emit
// reset clears the fill count and sets decay to 5; the table itself is not cleared
// a front stage and a two-tick queue keep taking ticks while the back is busy
// a stall on out_ch holds the emission pass on its current entry
module neighbour_table_aging #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  nta_in_if.sink      in_ch,
  nta_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  localparam int CNTW = $clog2(TABLE_DEPTH + 1);

  logic            push_valid;
  nta_pkg::tick_t  push_item;
  logic            q_full;
  logic            pop_ready;
  logic            pop_valid;
  nta_pkg::tick_t  pop_item;
  logic [CNTW-1:0] fill_count;

  // front: accepts and classifies ticks
  nta_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_full  (q_full)
  );

  // queue between front and back
  nta_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .full       (q_full),
    .pop_ready  (pop_ready),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item)
  );

  // back: table walk, append and emission
  nta_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop_ready  (pop_ready),
    .out_ch     (out_ch),
    .fill_count (fill_count)
  );

`ifndef SYNTH
  // table never holds more than its depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_count <= CNTW'(TABLE_DEPTH))
    else $error("fill count above table depth");

  // entries are only ever appended
  a_fill_grows: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> fill_count >= $past(fill_count))
    else $error("fill count decreased");

  // a dropped beacon implies a full table
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.beacon_dropped |-> fill_count == CNTW'(TABLE_DEPTH))
    else $error("beacon dropped while table not full");

  // the empty-table result is the only one of its tick
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.entry_valid |-> out_ch.last)
    else $error("empty-table result without last");
`endif

endmodule
